// ===== rtl/core/tfd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfd_pkg: shared types and constants for the TPKT frame delimiter
// Byte classes, sequencer states, result beat layout and queue sizing.
// ----------------------------------------------------------------------------
package tfd_pkg;

	localparam logic [7:0]  SYNC_BYTE   = 8'h03;
	localparam logic [7:0]  SYNC_NEXT   = 8'h00;
	localparam logic [15:0] HEADER_LEN  = 16'd4;
	localparam logic [15:0] DEFAULT_MAX = 16'd8192;

	// result queue: two slots are reserved per processed byte
	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = $clog2(Q_DEPTH);
	localparam int Q_CW    = $clog2(Q_DEPTH + 1);

	typedef enum logic [2:0] {
		CLS_DISCARD = 3'd0,
		CLS_START   = 3'd1,
		CLS_BODY    = 3'd2,
		CLS_END     = 3'd3,
		CLS_ABORT   = 3'd4
	} byte_class_t;

	typedef enum logic [5:0] {
		PH_START = 6'b000001,
		PH_HUNT  = 6'b000010,
		PH_HDR1  = 6'b000100,
		PH_LENHI = 6'b001000,
		PH_LENLO = 6'b010000,
		PH_BODY  = 6'b100000
	} phase_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		byte_class_t byte_class;
		logic [15:0] frame_length;
		logic        last_of_run;
	} result_t;

endpackage

// ===== rtl/core/tfd_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfd_in_if: raw byte stream channel
// valid/ready handshake carrying one received byte per beat.
// ----------------------------------------------------------------------------
interface tfd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink   (input valid, input data_byte, output ready);
endinterface

// ===== rtl/core/tfd_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfd_out_if: classified byte channel
// valid/ready handshake carrying one tagged byte per beat.
// ----------------------------------------------------------------------------
interface tfd_out_if;
	logic                 valid;
	logic                 ready;
	logic [7:0]           out_byte;
	tfd_pkg::byte_class_t byte_class;
	logic [15:0]          frame_length;
	logic                 last_of_run;

	modport source (output valid, output out_byte, output byte_class,
		output frame_length, output last_of_run, input ready);
	modport sink   (input valid, input out_byte, input byte_class,
		input frame_length, input last_of_run, output ready);
endinterface

// ===== rtl/core/tpkt_frame_delimiter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpkt_frame_delimiter: TPKT (RFC 1006) frame delimiter
// Tags each received byte as discarded, frame start, body, frame end or
// aborted, and reports the header length of the frame it belongs to.
// ----------------------------------------------------------------------------
// Usage: feed raw transport bytes on "raw", one per beat; every byte comes
// back on "frames" tagged with its class, plus the frame length once both
// header length bytes are seen. A byte is taken every clock as long as the
// result side keeps up. An accepted byte passes through the input register, then
// the result queue, before its first result beat. Most bytes give one
// result beat; while hunting for sync a byte can give two (the held 0x03 and
// itself), so such bytes add an extra result beat, absorbed by the four-entry
// result queue. The only loop is the per-byte update of the framing state.
// No clearing pass after reset.
// max_frame_length is written through cfg_we/cfg_wdata; the user must do so only
// while the block is idle, which the block does not enforce; it resets to 8192.
// ----------------------------------------------------------------------------
module tpkt_frame_delimiter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	tfd_in_if.sink      raw,
	tfd_out_if.source   frames
);

	// --- config ---
	logic [15:0] max_len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= tfd_pkg::DEFAULT_MAX;
		end else if (cfg_we) begin
			max_len_q <= cfg_wdata;
		end
	end

	// --- input register ---
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       s1_fire;
	logic       q_room;

	assign raw.ready = !valid_s1 || s1_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (raw.ready) begin
			valid_s1 <= raw.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (raw.ready && raw.valid) begin
			byte_s1 <= raw.data_byte;
		end
	end

	// --- framing state ---
	tfd_pkg::phase_t phase_q, phase_d;
	logic            sync_held_q, sync_held_d;
	logic [7:0]      length_high_q, length_high_d;
	logic [15:0]     total_length_q, total_length_d;
	logic [15:0]     byte_count_q, byte_count_d;

	logic [1:0]       n_res;
	tfd_pkg::result_t res0, res1;
	logic [15:0]      hdr_len;
	logic [15:0]      cnt_inc;

	assign hdr_len = {length_high_q, byte_s1};
	assign cnt_inc = byte_count_q + 16'd1;
	assign s1_fire = valid_s1 && q_room;

	always_comb begin
		phase_d        = phase_q;
		sync_held_d    = sync_held_q;
		length_high_d  = length_high_q;
		total_length_d = total_length_q;
		byte_count_d   = byte_count_q;
		n_res          = 2'd0;
		res0           = '{out_byte: byte_s1, byte_class: tfd_pkg::CLS_DISCARD,
			frame_length: 16'd0, last_of_run: 1'b0};
		res1           = '{out_byte: byte_s1, byte_class: tfd_pkg::CLS_DISCARD,
			frame_length: 16'd0, last_of_run: 1'b1};

		unique case (phase_q)
			tfd_pkg::PH_HUNT: begin
				if (sync_held_q) begin
					// held 0x03 always goes out first
					res0.out_byte = tfd_pkg::SYNC_BYTE;
					if (byte_s1 == tfd_pkg::SYNC_NEXT) begin
						res0.byte_class = tfd_pkg::CLS_START;
						res1.byte_class = tfd_pkg::CLS_BODY;
						n_res           = 2'd2;
						sync_held_d     = 1'b0;
						byte_count_d    = 16'd2;
						phase_d         = tfd_pkg::PH_LENHI;
					end else if (byte_s1 == tfd_pkg::SYNC_BYTE) begin
						// new 0x03 replaces the held one
						n_res = 2'd1;
					end else begin
						n_res       = 2'd2;
						sync_held_d = 1'b0;
					end
				end else if (byte_s1 == tfd_pkg::SYNC_BYTE) begin
					sync_held_d = 1'b1;
				end else begin
					n_res = 2'd1;
				end
			end
			tfd_pkg::PH_HDR1: begin
				res0.byte_class = tfd_pkg::CLS_BODY;
				n_res           = 2'd1;
				byte_count_d    = 16'd2;
				phase_d         = tfd_pkg::PH_LENHI;
			end
			tfd_pkg::PH_LENHI: begin
				res0.byte_class = tfd_pkg::CLS_BODY;
				n_res           = 2'd1;
				length_high_d   = byte_s1;
				byte_count_d    = 16'd3;
				phase_d         = tfd_pkg::PH_LENLO;
			end
			tfd_pkg::PH_LENLO: begin
				total_length_d    = hdr_len;
				byte_count_d      = tfd_pkg::HEADER_LEN;
				res0.frame_length = hdr_len;
				n_res             = 2'd1;
				if (hdr_len > max_len_q || hdr_len < tfd_pkg::HEADER_LEN) begin
					res0.byte_class = tfd_pkg::CLS_ABORT;
					sync_held_d     = 1'b0;
					phase_d         = tfd_pkg::PH_HUNT;
				end else if (hdr_len == tfd_pkg::HEADER_LEN) begin
					res0.byte_class = tfd_pkg::CLS_END;
					phase_d         = tfd_pkg::PH_START;
				end else begin
					res0.byte_class = tfd_pkg::CLS_BODY;
					phase_d         = tfd_pkg::PH_BODY;
				end
			end
			tfd_pkg::PH_BODY: begin
				byte_count_d      = cnt_inc;
				res0.frame_length = total_length_q;
				n_res             = 2'd1;
				if (cnt_inc >= total_length_q) begin
					res0.byte_class = tfd_pkg::CLS_END;
					phase_d         = tfd_pkg::PH_START;
				end else begin
					res0.byte_class = tfd_pkg::CLS_BODY;
				end
			end
			default: begin
				// frame boundary; stray codes land here too
				n_res = 2'd1;
				if (byte_s1 == tfd_pkg::SYNC_BYTE) begin
					res0.byte_class = tfd_pkg::CLS_START;
					byte_count_d    = 16'd1;
					phase_d         = tfd_pkg::PH_HDR1;
				end else begin
					sync_held_d = 1'b0;
					phase_d     = tfd_pkg::PH_HUNT;
				end
			end
		endcase

		res0.last_of_run = (n_res == 2'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= tfd_pkg::PH_START;
			sync_held_q    <= 1'b0;
			length_high_q  <= 8'd0;
			total_length_q <= 16'd0;
			byte_count_q   <= 16'd0;
		end else if (s1_fire) begin
			phase_q        <= phase_d;
			sync_held_q    <= sync_held_d;
			length_high_q  <= length_high_d;
			total_length_q <= total_length_d;
			byte_count_q   <= byte_count_d;
		end
	end

	// --- result queue: up to two writes, one read per cycle ---
	tfd_pkg::result_t            queue_q [tfd_pkg::Q_DEPTH];
	logic [tfd_pkg::Q_AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [tfd_pkg::Q_CW-1:0]    count_q;
	logic [1:0]                  push_n;
	logic                        pop;

	assign q_room = count_q <= tfd_pkg::Q_CW'(tfd_pkg::Q_DEPTH - 2);
	assign push_n = s1_fire ? n_res : 2'd0;
	assign pop    = frames.valid && frames.ready;

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			queue_q[wr_ptr_q] <= res0;
		end
		if (push_n == 2'd2) begin
			queue_q[wr_ptr_q + tfd_pkg::Q_AW'(1)] <= res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + tfd_pkg::Q_AW'(push_n);
			rd_ptr_q <= rd_ptr_q + tfd_pkg::Q_AW'(pop);
			count_q  <= count_q + tfd_pkg::Q_CW'(push_n) - tfd_pkg::Q_CW'(pop);
		end
	end

	assign frames.valid        = count_q != '0;
	assign frames.out_byte     = queue_q[rd_ptr_q].out_byte;
	assign frames.byte_class   = queue_q[rd_ptr_q].byte_class;
	assign frames.frame_length = queue_q[rd_ptr_q].frame_length;
	assign frames.last_of_run  = queue_q[rd_ptr_q].last_of_run;

endmodule

// ===== rtl/core/tfd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfd_checker: port-level checks for the TPKT frame delimiter
// Watches the result channel; bound to the top level.
// ----------------------------------------------------------------------------
module tfd_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 valid,
	input logic                 ready,
	input logic [7:0]           out_byte,
	input tfd_pkg::byte_class_t byte_class,
	input logic [15:0]          frame_length,
	input logic                 last_of_run
);

	// stalled beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid && $stable(out_byte) && $stable(byte_class)
			&& $stable(frame_length) && $stable(last_of_run))
		else $error("result beat changed while stalled");

	// start is emitted before the length is known
	a_start_len: assert property (@(posedge clk) disable iff (!arst_n)
		valid && byte_class == tfd_pkg::CLS_START |-> frame_length == 16'd0)
		else $error("frame start carries a length");

	// abort only on the low length byte, which yields a single beat
	a_abort_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid && byte_class == tfd_pkg::CLS_ABORT |-> last_of_run)
		else $error("abort not last of run");

	// an accepted frame is at least a header long
	a_end_len: assert property (@(posedge clk) disable iff (!arst_n)
		valid && byte_class == tfd_pkg::CLS_END |-> frame_length >= tfd_pkg::HEADER_LEN)
		else $error("frame end with short length");

	// the held sync byte always precedes a second beat
	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		valid && ready && !last_of_run |-> out_byte == tfd_pkg::SYNC_BYTE)
		else $error("first of two beats is not the held sync byte");

endmodule

bind tpkt_frame_delimiter tfd_checker u_tfd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.valid        (frames.valid),
	.ready        (frames.ready),
	.out_byte     (frames.out_byte),
	.byte_class   (frames.byte_class),
	.frame_length (frames.frame_length),
	.last_of_run  (frames.last_of_run)
);
